FILE: hdl/aie_pkg.sv
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types and constants for the arithmetic interval encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package aie_pkg;

  localparam int RANGE_BITS = 32;
  localparam int LOW_W      = RANGE_BITS;
  localparam int HIGH_W     = RANGE_BITS + 1;
  localparam int CUM_LO_W   = 30;
  localparam int CUM_W      = 31;
  localparam int FOLLOW_W   = 32;
  localparam int QUOT_W     = RANGE_BITS + 1;
  localparam int PROD_W     = RANGE_BITS + CUM_W;
  localparam int STEP_W     = $clog2(RANGE_BITS + 1);
  localparam int DCNT_W     = $clog2(QUOT_W + 1);

  localparam logic [HIGH_W-1:0] FULL    = HIGH_W'(1) << RANGE_BITS;
  localparam logic [HIGH_W-1:0] HALF    = HIGH_W'(1) << (RANGE_BITS - 1);
  localparam logic [HIGH_W-1:0] QUARTER = HIGH_W'(1) << (RANGE_BITS - 2);
  localparam logic [HIGH_W-1:0] THREE_Q = HALF + QUARTER;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [CUM_LO_W-1:0] cum_low;
    logic [CUM_W-1:0]    cum_high;
    logic [CUM_W-1:0]    total;
  } in_t;

  typedef struct packed {
    logic                bit_res;
    logic [FOLLOW_W-1:0] follow_count;
    logic                last;
  } out_t;

  typedef enum logic [1:0] {
    RULE_NONE,
    RULE_LOW,
    RULE_HIGH,
    RULE_MID
  } rule_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_DIV_HI,
    ST_MUL_LO,
    ST_DIV_LO,
    ST_RENORM,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic sel_lo;
    logic div_step;
    logic store_hi;
    logic update;
    logic renorm;
    logic flush;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic  div_done;
    rule_e rule;
    logic  stg_valid;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/aie_ctrl.sv
// ----------------------------------------------------------------------------
// aie_ctrl
// Sequencer for narrowing, division, renormalization and finish of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module aie_ctrl import aie_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic opcode_i,
  output logic      in_ready_o,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (opcode_i == OP_FINISH) ? ST_FINISH : ST_MUL_HI;
        end
      end
      ST_MUL_HI: state_d = ST_DIV_HI;
      ST_DIV_HI: if (sts_i.div_done) state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_DIV_LO;
      ST_DIV_LO: if (sts_i.div_done) state_d = ST_RENORM;
      ST_RENORM: begin
        if (sts_i.rule == RULE_NONE) begin
          if (!sts_i.stg_valid || sts_i.out_free) state_d = ST_IDLE;
        end
      end
      ST_FINISH: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL_HI: cmd_o.mul_start = 1'b1;
      ST_DIV_HI: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.store_hi = sts_i.div_done;
      end
      ST_MUL_LO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.sel_lo    = 1'b1;
      end
      ST_DIV_LO: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.update   = sts_i.div_done;
      end
      ST_RENORM: begin
        unique case (sts_i.rule) inside
          RULE_NONE: cmd_o.flush = sts_i.stg_valid && sts_i.out_free;
          RULE_MID:  cmd_o.renorm = 1'b1;
          // a new emission pushes the staged one out; wait for room
          RULE_LOW, RULE_HIGH: cmd_o.renorm = !sts_i.stg_valid || sts_i.out_free;
          default:   cmd_o.renorm = 1'b0;
        endcase
      end
      ST_FINISH: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/aie_datapath.sv
// ----------------------------------------------------------------------------
// aie_datapath
// Interval registers, multiplier, radix-2 divider, renorm logic, output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aie_datapath import aie_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  in_t       in_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  logic [LOW_W-1:0]    low_q, low_d;
  logic [HIGH_W-1:0]   high_q, high_d;
  logic [FOLLOW_W-1:0] pend_q, pend_d;
  logic [HIGH_W-1:0]   nh_q, nh_d;
  logic [CUM_W-1:0]    tot_q, tot_d, ch_q, ch_d;
  logic [CUM_LO_W-1:0] cl_q, cl_d;
  logic [CUM_W-1:0]    rem_q, rem_d;
  logic [QUOT_W-1:0]   dq_q, dq_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic                stg_valid_q, stg_valid_d, stg_bit_q, stg_bit_d;
  logic [FOLLOW_W-1:0] stg_follow_q, stg_follow_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic [CUM_W-1:0]    tot_s, ch_a, ch_s, cl_ext;
  logic [HIGH_W-1:0]   width;
  logic [CUM_W-1:0]    mul_op;
  logic [63:0]         prod;
  logic [CUM_W:0]      r2, r2_sub;
  logic                ge;
  rule_e               rule;
  logic                out_free, fin_c;
  logic [FOLLOW_W-1:0] pend_inc;

  // operand cleanup for malformed frequencies
  always_comb begin
    tot_s  = (in_i.total == '0) ? CUM_W'(1) : in_i.total;
    ch_a   = (in_i.cum_high > tot_s) ? tot_s : in_i.cum_high;
    ch_s   = (ch_a == '0) ? CUM_W'(1) : ch_a;
    cl_ext = {1'b0, in_i.cum_low};
    if (cl_ext >= ch_s) cl_ext = ch_s - CUM_W'(1);
  end

  assign width  = high_q - {1'b0, low_q};
  assign mul_op = cmd_i.sel_lo ? {1'b0, cl_q} : ch_q;
  assign prod   = 64'(width) * 64'(mul_op);

  assign r2     = {rem_q, dq_q[QUOT_W-1]};
  assign r2_sub = r2 - {1'b0, tot_q};
  assign ge     = r2 >= {1'b0, tot_q};

  always_comb begin
    if (steps_q == STEP_W'(RANGE_BITS))                           rule = RULE_NONE;
    else if (high_q <= HALF)                                      rule = RULE_LOW;
    else if ({1'b0, low_q} >= HALF)                               rule = RULE_HIGH;
    else if ({1'b0, low_q} >= QUARTER && high_q <= THREE_Q)       rule = RULE_MID;
    else                                                          rule = RULE_NONE;
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign pend_inc = (pend_q == '1) ? pend_q : pend_q + FOLLOW_W'(1);
  assign fin_c    = ({1'b0, low_q} <= QUARTER) && (high_q >= HALF);

  always_comb begin
    low_d        = low_q;
    high_d       = high_q;
    pend_d       = pend_q;
    nh_d         = nh_q;
    tot_d        = tot_q;
    ch_d         = ch_q;
    cl_d         = cl_q;
    rem_d        = rem_q;
    dq_d         = dq_q;
    dcnt_d       = dcnt_q;
    steps_d      = steps_q;
    stg_valid_d  = stg_valid_q;
    stg_bit_d    = stg_bit_q;
    stg_follow_d = stg_follow_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cmd_i.load) begin
      tot_d = tot_s;
      ch_d  = ch_s;
      cl_d  = cl_ext[CUM_LO_W-1:0];
    end
    if (cmd_i.mul_start) begin
      rem_d  = CUM_W'(prod[PROD_W-1:QUOT_W]);
      dq_d   = prod[QUOT_W-1:0];
      dcnt_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d  = ge ? r2_sub[CUM_W-1:0] : r2[CUM_W-1:0];
      dq_d   = {dq_q[QUOT_W-2:0], ge};
      dcnt_d = dcnt_q + DCNT_W'(1);
    end
    if (cmd_i.store_hi) nh_d = {1'b0, low_q} + dq_q;
    if (cmd_i.update) begin
      high_d  = nh_q;
      low_d   = low_q + dq_q[LOW_W-1:0];
      steps_d = '0;
    end
    if (cmd_i.renorm) begin
      steps_d = steps_q + STEP_W'(1);
      unique case (rule)
        RULE_LOW: begin
          low_d  = {low_q[LOW_W-2:0], 1'b0};
          high_d = {high_q[HIGH_W-2:0], 1'b0};
        end
        RULE_HIGH: begin
          low_d  = {low_q[LOW_W-2:0], 1'b0};
          high_d = {high_q[HIGH_W-2:0] - HALF[HIGH_W-2:0], 1'b0};
        end
        RULE_MID: begin
          low_d  = {low_q[LOW_W-2:0] - QUARTER[LOW_W-2:0], 1'b0};
          high_d = {high_q[HIGH_W-2:0] - QUARTER[HIGH_W-2:0], 1'b0};
          pend_d = pend_inc;
        end
        default: ;
      endcase
      if (rule == RULE_LOW || rule == RULE_HIGH) begin
        // stage this emission; release the previous one as a non-final beat
        if (stg_valid_q) begin
          out_d       = '{bit_res: stg_bit_q, follow_count: stg_follow_q, last: 1'b0};
          out_valid_d = 1'b1;
        end
        stg_valid_d  = 1'b1;
        stg_bit_d    = (rule == RULE_HIGH);
        stg_follow_d = pend_q;
        pend_d       = '0;
      end
    end
    if (cmd_i.flush) begin
      out_d       = '{bit_res: stg_bit_q, follow_count: stg_follow_q, last: 1'b1};
      out_valid_d = 1'b1;
      stg_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_d       = '{bit_res: !fin_c, follow_count: pend_inc, last: 1'b1};
      out_valid_d = 1'b1;
      low_d       = '0;
      high_d      = FULL;
      pend_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= FULL;
      pend_q      <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      steps_q     <= '0;
    end else begin
      low_q       <= low_d;
      high_q      <= high_d;
      pend_q      <= pend_d;
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
      steps_q     <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nh_q         <= nh_d;
    tot_q        <= tot_d;
    ch_q         <= ch_d;
    cl_q         <= cl_d;
    rem_q        <= rem_d;
    dq_q         <= dq_d;
    stg_bit_q    <= stg_bit_d;
    stg_follow_q <= stg_follow_d;
    out_q        <= out_d;
  end

  assign sts_o = '{div_done: (dcnt_q == DCNT_W'(QUOT_W)), rule: rule,
                   stg_valid: stg_valid_q, out_free: out_free};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: hdl/arithmetic_interval_encoder.sv
// ----------------------------------------------------------------------------
// arithmetic_interval_encoder
// Binary arithmetic coder core with underflow bit counting.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid_i/in_ready_o   | in_i  : opcode, cum_low, cum_high, total
//  out     | out_valid_o/out_ready_i | out_o : bit_res, follow_count, last
//
// An encode item takes a load, two multiply-and-divide passes of a multiply,
// the divide and a result write (one quotient bit per cycle in the shared divider),
// then up to 32 renormalization steps and a closing step. A finish item
// waits for a free output register. Each beat is held one step in a staging
// register so the final one can carry last; a full output register stalls
// the renormalization steps that emit a bit. Reset puts the interval at
// [0, 2^32) with no pending bits.
// ----------------------------------------------------------------------------
`default_nettype none

module arithmetic_interval_encoder import aie_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  in_t       in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  cmd_t cmd;
  sts_t sts;

  aie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aie_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
